FILE: rtl/b64e_pkg.sv
// ----------------------------------------------------------------------------
// b64e_pkg
// Shared types, constants and the character table for the base64 encoder.
// ----------------------------------------------------------------------------
package b64e_pkg;

    // group queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [7:0] PAD_CHAR    = 8'h3D;
    localparam logic [5:0] SEXTET_MASK = 6'h3F;

    // pad counts
    localparam logic [1:0] PADS_NONE = 2'd0;
    localparam logic [1:0] PADS_ONE  = 2'd1;
    localparam logic [1:0] PADS_TWO  = 2'd2;

    // character position codes within a group
    localparam logic [1:0] POS_FIRST  = 2'd0;
    localparam logic [1:0] POS_SECOND = 2'd1;
    localparam logic [1:0] POS_THIRD  = 2'd2;
    localparam logic [1:0] POS_FOURTH = 2'd3;

    // one group of up to three bytes ready to be serialized
    typedef struct packed {
        logic [23:0] triple;
        logic [1:0]  pads;
        logic        last;
    } t_group;

    // standard alphabet lookup
    function automatic logic [7:0] b64_char(input logic [5:0] idx);
        logic [7:0] v;
        v = {2'b00, idx & SEXTET_MASK};
        if (v < 8'd26) begin
            b64_char = 8'h41 + v;
        end else if (v < 8'd52) begin
            b64_char = 8'h61 + (v - 8'd26);
        end else if (v < 8'd62) begin
            b64_char = 8'h30 + (v - 8'd52);
        end else if (v == 8'd62) begin
            b64_char = 8'h2B;
        end else begin
            b64_char = 8'h2F;
        end
    endfunction

endpackage

FILE: rtl/b64e_front.sv
// ----------------------------------------------------------------------------
// b64e_front
// Accepts bytes, holds up to two pending bytes and forms full groups and padded final groups.
// ----------------------------------------------------------------------------
module b64e_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_data_byte,
    input  logic             i_final_byte,
    output logic             o_push,
    output b64e_pkg::t_group o_group
);

    logic [15:0] r_pend, n_pend;
    logic [1:0]  r_cnt, n_cnt;

    // group assembly and pending byte update
    always_comb begin
        n_pend  = r_pend;
        n_cnt   = r_cnt;
        o_push  = 1'b0;
        o_group = '0;
        if (i_accept) begin
            if (r_cnt[1]) begin
                o_push         = 1'b1;
                o_group.triple = {r_pend, i_data_byte};
                o_group.pads   = b64e_pkg::PADS_NONE;
                o_group.last   = i_final_byte;
                n_pend         = '0;
                n_cnt          = '0;
            end else if (i_final_byte) begin
                o_push       = 1'b1;
                o_group.last = 1'b1;
                if (r_cnt[0]) begin
                    o_group.triple = {r_pend[7:0], i_data_byte, 8'h00};
                    o_group.pads   = b64e_pkg::PADS_ONE;
                end else begin
                    o_group.triple = {i_data_byte, 16'h0000};
                    o_group.pads   = b64e_pkg::PADS_TWO;
                end
                n_pend = '0;
                n_cnt  = '0;
            end else begin
                n_pend = {r_pend[7:0], i_data_byte};
                n_cnt  = r_cnt + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
            r_cnt  <= '0;
        end else begin
            r_pend <= n_pend;
            r_cnt  <= n_cnt;
        end
    end

    // pending count never reaches three
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("pending count out of range");

    // a full group is always released on the third byte
    a_third_pushes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && r_cnt == 2'd2) |-> o_push) else $error("third byte not released");

endmodule

FILE: rtl/b64e_fifo.sv
// ----------------------------------------------------------------------------
// b64e_fifo
// Short group queue decoupling byte intake from character output.
// ----------------------------------------------------------------------------
module b64e_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  b64e_pkg::t_group i_group,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_valid,
    output b64e_pkg::t_group o_group
);

    b64e_pkg::t_group                r_mem [b64e_pkg::QDEPTH];
    logic [b64e_pkg::QPTR_W-1:0]     r_wr, n_wr, r_rd, n_rd;
    logic [b64e_pkg::QCNT_W-1:0]     r_cnt, n_cnt;

    assign o_full  = (r_cnt == b64e_pkg::QCNT_W'(b64e_pkg::QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_group = r_mem[r_rd];

    // pointer and count update
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == b64e_pkg::QPTR_W'(b64e_pkg::QDEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == b64e_pkg::QPTR_W'(b64e_pkg::QDEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_group;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full) else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid) else $error("pop from empty queue");

endmodule

FILE: rtl/b64e_back.sv
// ----------------------------------------------------------------------------
// b64e_back
// Serializes queued groups into four characters, one per cycle while the
// output is ready, into an output register.
// ----------------------------------------------------------------------------
module b64e_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  b64e_pkg::t_group i_group,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [7:0]       o_out_char,
    output logic             o_group_end,
    output logic             o_message_end
);

    logic       r_valid;
    logic [1:0] r_k;
    logic [7:0] r_char;
    logic       r_gend, r_mend;
    logic       load;
    logic [5:0] sextet;
    logic       pad;
    logic [7:0] n_char;

    assign load  = i_q_valid && (!r_valid || i_ready);
    assign o_pop = load && (r_k == b64e_pkg::POS_FOURTH);

    // sextet select by character position
    always_comb begin
        case (r_k)
            b64e_pkg::POS_FIRST:  sextet = i_group.triple[23:18];
            b64e_pkg::POS_SECOND: sextet = i_group.triple[17:12];
            b64e_pkg::POS_THIRD:  sextet = i_group.triple[11:6];
            default:              sextet = i_group.triple[5:0];
        endcase
    end

    // padding occupies the trailing positions
    always_comb begin
        case (i_group.pads)
            b64e_pkg::PADS_TWO: pad = r_k[1];
            b64e_pkg::PADS_ONE: pad = (r_k == b64e_pkg::POS_FOURTH);
            default:            pad = 1'b0;
        endcase
        n_char = pad ? b64e_pkg::PAD_CHAR : b64e_pkg::b64_char(sextet);
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_k     <= b64e_pkg::POS_FIRST;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_k     <= r_k + 2'd1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // output payload register
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_char <= n_char;
            r_gend <= (r_k == b64e_pkg::POS_FOURTH);
            r_mend <= (r_k == b64e_pkg::POS_FOURTH) && i_group.last;
        end
    end

    assign o_valid       = r_valid;
    assign o_out_char    = r_char;
    assign o_group_end   = r_gend;
    assign o_message_end = r_mend;

    a_mend_on_gend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_mend) |-> r_gend) else $error("message end off group end");

    a_gend_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(load) && r_gend |-> (r_k == b64e_pkg::POS_FIRST))
        else $error("group end out of position");

endmodule

FILE: rtl/base64_stream_encoder.sv
// ----------------------------------------------------------------------------
// base64_stream_encoder
// Streaming base64 encoder, standard alphabet with '=' padding.
// ----------------------------------------------------------------------------
// One raw byte enters per item; the final_byte flag closes the message. The
// front stage takes a byte in every cycle while the two-entry group queue has
// room, and releases a group on the third byte or on the final byte. The back
// stage emits one character per cycle while the output is ready, from the
// head group into an output register, so a group yields four characters;
// the single-character output path limits throughput. A released group
// reaches the output through the group queue and then the output register.
// No clearing pass follows reset.
// ----------------------------------------------------------------------------
module base64_stream_encoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_final_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_char,
    output logic       o_group_end,
    output logic       o_message_end
);

    logic             accept;
    logic             push;
    logic             pop;
    logic             q_full;
    logic             q_valid;
    b64e_pkg::t_group grp_in;
    b64e_pkg::t_group grp_head;

    assign o_in_ready = !q_full;
    assign accept     = i_in_valid && o_in_ready;

    // byte intake and group assembly
    b64e_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_data_byte  (i_data_byte),
        .i_final_byte (i_final_byte),
        .o_push       (push),
        .o_group      (grp_in)
    );

    // group queue
    b64e_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_group (grp_in),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_group (grp_head)
    );

    // character serializer
    b64e_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_group       (grp_head),
        .o_pop         (pop),
        .o_valid       (o_out_valid),
        .i_ready       (i_out_ready),
        .o_out_char    (o_out_char),
        .o_group_end   (o_group_end),
        .o_message_end (o_message_end)
    );

endmodule
